@@ sv/tccv_pkg.sv @@
`default_nettype none
package tccv_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_X,
		ST_DIV_Y,
		ST_DIV_Z,
		ST_DIV_W,
		ST_DOT,
		ST_SCR_X,
		ST_SCR_Y,
		ST_STORE,
		ST_OUT
	} tccv_state_t;

	typedef enum logic [1:0] {
		DIV_SEL_X,
		DIV_SEL_Y,
		DIV_SEL_Z,
		DIV_SEL_ONE
	} tccv_div_sel_t;

	typedef struct packed {
		logic          load;
		logic          div_start;
		tccv_div_sel_t div_sel;
		logic          div_capture;
		logic          dot_step;
		logic          scr_x;
		logic          scr_y;
		logic          store;
		logic          out_load;
		logic          out_next;
	} tccv_cmd_t;

	typedef struct packed {
		logic div_done;
		logic dot_done;
		logic last_vertex;
		logic emit;
		logic out_last;
	} tccv_sts_t;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_CULL   = 3'd2;
	localparam logic [2:0] REG_CAM_X  = 3'd3;
	localparam logic [2:0] REG_CAM_Y  = 3'd4;
	localparam logic [2:0] REG_CAM_Z  = 3'd5;

endpackage
`default_nettype wire

@@ sv/triangle_clip_cull_viewport_core.sv @@
// Vertex clip, cull and viewport stage. Each vertex (clip-space position,
// normal, world position) takes one request and passes through four
// restoring divisions (x/w, y/w, z/w, 1/w; 64 steps each) on one shared
// divider, then the dot product (the first product overlaps the last
// division), the viewport mapping of x and then y, a store step and the
// idle state that takes the request.
// After the third vertex a surviving triangle leaves as three results,
// slots 0..2, with last_of_triangle on slot 2; no new request is taken until
// they are delivered. Configuration lives on an APB port at byte address 4*i.
`default_nettype none
module triangle_clip_cull_viewport_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] clip_x,
	input  wire logic [31:0] clip_y,
	input  wire logic [31:0] clip_z,
	input  wire logic [31:0] clip_w,
	input  wire logic [31:0] normal_x,
	input  wire logic [31:0] normal_y,
	input  wire logic [31:0] normal_z,
	input  wire logic [31:0] world_x,
	input  wire logic [31:0] world_y,
	input  wire logic [31:0] world_z,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [28:0]      screen_x,
	output logic [28:0]      screen_y,
	output logic [16:0]      depth,
	output logic [31:0]      inverse_w,
	output logic [1:0]       vertex_slot,
	output logic             last_of_triangle
);
	import tccv_pkg::*;

	logic [12:0] width_q, height_q;
	logic        cull_q;
	logic [31:0] camx_q, camy_q, camz_q;
	logic        wr;
	tccv_cmd_t   cmd;
	tccv_sts_t   sts;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			height_q <= 13'd480;
			cull_q   <= 1'b0;
			camx_q   <= '0;
			camy_q   <= '0;
			camz_q   <= '0;
		end else if (wr && paddr[1:0] == 2'b00) begin
			unique case (paddr[4:2])
				REG_WIDTH:  width_q  <= pwdata[12:0];
				REG_HEIGHT: height_q <= pwdata[12:0];
				REG_CULL:   cull_q   <= pwdata[0];
				REG_CAM_X:  camx_q   <= pwdata;
				REG_CAM_Y:  camy_q   <= pwdata;
				REG_CAM_Z:  camz_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_WIDTH:  prdata = {19'd0, width_q};
			REG_HEIGHT: prdata = {19'd0, height_q};
			REG_CULL:   prdata = {31'd0, cull_q};
			REG_CAM_X:  prdata = camx_q;
			REG_CAM_Y:  prdata = camy_q;
			REG_CAM_Z:  prdata = camz_q;
			default:    prdata = '0;
		endcase
	end

	tccv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_stall(out_stall), .out_valid(out_valid), .sts(sts), .cmd(cmd)
	);

	tccv_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.clip_x(clip_x), .clip_y(clip_y), .clip_z(clip_z), .clip_w(clip_w),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.world_x(world_x), .world_y(world_y), .world_z(world_z),
		.cfg_width(width_q), .cfg_height(height_q), .cfg_cull(cull_q),
		.cam_x(camx_q), .cam_y(camy_q), .cam_z(camz_q),
		.screen_x(screen_x), .screen_y(screen_y), .depth(depth),
		.inverse_w(inverse_w), .vertex_slot(vertex_slot),
		.last_of_triangle(last_of_triangle)
	);
endmodule
`default_nettype wire

@@ sv/tccv_div.sv @@
`default_nettype none
module tccv_div #(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	input  wire logic         neg,
	output logic              done,
	output logic [W-1:0]      quotient
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0]  q_q, r_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, neg_q;
	logic [W:0]    trial;
	logic [W:0]    rs;

	assign rs = {r_q, q_q[W-1]};
	assign trial = rs - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			r_q   <= '0;
			d_q   <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= rs[W-1:0];
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? (~q_q + 1'b1) : q_q;
endmodule
`default_nettype wire

@@ sv/tccv_ctrl.sv @@
`default_nettype none
module tccv_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               out_stall,
	output logic                    out_valid,
	input  wire tccv_pkg::tccv_sts_t sts,
	output tccv_pkg::tccv_cmd_t     cmd
);
	import tccv_pkg::*;

	tccv_state_t state_q, state_d;
	logic        ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				ov_q <= 1'b1;
			else if (ov_q && !out_stall && sts.out_last)
				ov_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_DIV_X;
			ST_DIV_X: if (sts.div_done) state_d = ST_DIV_Y;
			ST_DIV_Y: if (sts.div_done) state_d = ST_DIV_Z;
			ST_DIV_Z: if (sts.div_done) state_d = ST_DIV_W;
			ST_DIV_W: if (sts.div_done) state_d = ST_DOT;
			ST_DOT:   if (sts.dot_done) state_d = ST_SCR_X;
			ST_SCR_X: state_d = ST_SCR_Y;
			ST_SCR_Y: state_d = ST_STORE;
			ST_STORE: state_d = (sts.last_vertex && sts.emit) ? ST_OUT : ST_IDLE;
			ST_OUT:   if (!out_stall && sts.out_last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = DIV_SEL_X;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load      = in_valid;
				cmd.div_start = in_valid;
			end
			ST_DIV_X: begin
				cmd.div_sel     = DIV_SEL_X;
				cmd.div_capture = sts.div_done;
				cmd.div_start   = sts.div_done;
				if (sts.div_done) cmd.div_sel = DIV_SEL_Y;
			end
			ST_DIV_Y: begin
				cmd.div_sel     = DIV_SEL_Y;
				cmd.div_capture = sts.div_done;
				cmd.div_start   = sts.div_done;
				if (sts.div_done) cmd.div_sel = DIV_SEL_Z;
			end
			ST_DIV_Z: begin
				cmd.div_sel     = DIV_SEL_Z;
				cmd.div_capture = sts.div_done;
				cmd.div_start   = sts.div_done;
				if (sts.div_done) cmd.div_sel = DIV_SEL_ONE;
			end
			ST_DIV_W: begin
				cmd.div_sel     = DIV_SEL_ONE;
				cmd.div_capture = sts.div_done;
				cmd.dot_step    = sts.div_done;
			end
			ST_DOT:   cmd.dot_step = 1'b1;
			ST_SCR_X: cmd.scr_x = 1'b1;
			ST_SCR_Y: cmd.scr_y = 1'b1;
			ST_STORE: begin
				cmd.store    = 1'b1;
				cmd.out_load = sts.last_vertex && sts.emit;
			end
			ST_OUT:   cmd.out_next = !out_stall && !sts.out_last;
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = ov_q;

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT) else $error("result outside output state");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("accept while busy");
	a_emit_from_store: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_STORE) else $error("bad emit");
endmodule
`default_nettype wire

@@ sv/tccv_dp.sv @@
`default_nettype none
module tccv_dp #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tccv_pkg::tccv_cmd_t cmd,
	output tccv_pkg::tccv_sts_t      sts,
	input  wire logic [31:0]         clip_x,
	input  wire logic [31:0]         clip_y,
	input  wire logic [31:0]         clip_z,
	input  wire logic [31:0]         clip_w,
	input  wire logic [31:0]         normal_x,
	input  wire logic [31:0]         normal_y,
	input  wire logic [31:0]         normal_z,
	input  wire logic [31:0]         world_x,
	input  wire logic [31:0]         world_y,
	input  wire logic [31:0]         world_z,
	input  wire logic [12:0]         cfg_width,
	input  wire logic [12:0]         cfg_height,
	input  wire logic                cfg_cull,
	input  wire logic [31:0]         cam_x,
	input  wire logic [31:0]         cam_y,
	input  wire logic [31:0]         cam_z,
	output logic [28:0]              screen_x,
	output logic [28:0]              screen_y,
	output logic [16:0]              depth,
	output logic [31:0]              inverse_w,
	output logic [1:0]               vertex_slot,
	output logic                     last_of_triangle
);
	import tccv_pkg::*;

	localparam int         DW  = 64;
	localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
	localparam logic [63:0] ONE2 = 64'd1 << (2 * FRAC_BITS);

	logic [31:0] x_q, y_q, z_q, w_q;
	logic [32:0] n_q [3];
	logic [32:0] d_q [3];
	logic [1:0]  dcnt_q;
	logic signed [67:0] acc_q;
	logic signed [63:0] qx_q, qy_q, qz_q, inv_q;
	logic [1:0]  vc_q;
	logic        rej_q, away_q;
	logic [28:0] sx_q, sy_q;
	logic [28:0] hx_q [2];
	logic [28:0] hy_q [2];
	logic [16:0] hd_q [2];
	logic [31:0] hi_q [2];
	logic [1:0]  oslot_q;

	logic signed [63:0] num;
	logic [63:0] num_mag, w_mag, quo;
	logic        div_neg, div_done;
	logic signed [63:0] w64;

	assign w64   = 64'(signed'(w_q));
	assign w_mag = w64[63] ? 64'(-w64) : w64;

	always_comb begin
		unique case (cmd.div_sel)
			DIV_SEL_X:   num = 64'(signed'(cmd.load ? clip_x : x_q)) <<< FRAC_BITS;
			DIV_SEL_Y:   num = 64'(signed'(y_q)) <<< FRAC_BITS;
			DIV_SEL_Z:   num = 64'(signed'(z_q)) <<< FRAC_BITS;
			DIV_SEL_ONE: num = signed'(ONE2);
			default:     num = '0;
		endcase
	end

	logic signed [63:0] ld_w;
	logic [63:0] ld_wmag;
	assign ld_w    = 64'(signed'(clip_w));
	assign ld_wmag = ld_w[63] ? 64'(-ld_w) : ld_w;
	assign num_mag = num[63] ? 64'(-num) : num;
	assign div_neg = num[63] ^ (cmd.load ? ld_w[63] : w64[63]);

	tccv_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(num_mag), .divisor(cmd.load ? ld_wmag : w_mag), .neg(div_neg),
		.done(div_done), .quotient(quo)
	);

	logic wz;
	assign wz = (w_q == '0);

	// dot product: one 33x33 product per cycle
	logic signed [65:0] prod;
	assign prod = signed'(n_q[dcnt_q]) * signed'(d_q[dcnt_q]);

	// viewport mapping
	logic signed [63:0] tq;
	logic [12:0]        sz;
	logic signed [63:0] t;
	logic [FRAC_BITS+1:0] tc;
	logic [FRAC_BITS+15:0] sprod;
	logic [FRAC_BITS+14:0] shalf;
	logic [28:0]         scl;
	assign tq = cmd.scr_x ? qx_q : qy_q;
	assign sz = cmd.scr_x ? cfg_width : cfg_height;
	assign t  = tq + signed'(ONE);
	always_comb begin
		if (t < 0) tc = '0;
		else if (t > signed'(ONE << 1)) tc = (FRAC_BITS+2)'(ONE << 1);
		else tc = t[FRAC_BITS+1:0];
	end
	assign sprod = tc * sz;
	assign shalf = sprod[FRAC_BITS+15:1];
	assign scl   = (shalf > (FRAC_BITS+15)'(29'h1FFFFFFF)) ? 29'h1FFFFFFF : 29'(shalf);

	logic [16:0] dpv;
	logic [31:0] ivv;
	always_comb begin
		if (qz_q < 0) dpv = '0;
		else if (qz_q > 64'sh1FFFF) dpv = 17'h1FFFF;
		else dpv = qz_q[16:0];
		if (inv_q > 64'sh7FFFFFFF) ivv = 32'h7FFFFFFF;
		else if (inv_q < -64'sh80000000) ivv = 32'h80000000;
		else ivv = inv_q[31:0];
	end

	logic rej_v, away_v, clipfail;
	assign clipfail = wz || qx_q > signed'(ONE) || qx_q < -signed'(ONE)
		|| qy_q > signed'(ONE) || qy_q < -signed'(ONE)
		|| qz_q > signed'(ONE) || qz_q < 0;
	assign rej_v  = rej_q || clipfail;
	assign away_v = away_q && !acc_q[67];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q    <= '0;
			rej_q   <= 1'b0;
			away_q  <= 1'b1;
			dcnt_q  <= '0;
			oslot_q <= '0;
		end else begin
			if (cmd.dot_step)
				dcnt_q <= (dcnt_q == 2'd2) ? 2'd0 : dcnt_q + 1'b1;
			if (cmd.store) begin
				if (vc_q == 2'd2) begin
					vc_q    <= '0;
					rej_q   <= 1'b0;
					away_q  <= 1'b1;
				end else begin
					vc_q   <= vc_q + 1'b1;
					rej_q  <= rej_v;
					away_q <= away_v;
				end
			end
			if (cmd.out_load)
				oslot_q <= '0;
			else if (cmd.out_next)
				oslot_q <= oslot_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= clip_x; y_q <= clip_y; z_q <= clip_z; w_q <= clip_w;
			n_q[0] <= 33'(signed'(normal_x));
			n_q[1] <= 33'(signed'(normal_y));
			n_q[2] <= 33'(signed'(normal_z));
			d_q[0] <= 33'(signed'(world_x)) - 33'(signed'(cam_x));
			d_q[1] <= 33'(signed'(world_y)) - 33'(signed'(cam_y));
			d_q[2] <= 33'(signed'(world_z)) - 33'(signed'(cam_z));
			acc_q  <= '0;
		end else if (cmd.dot_step)
			acc_q <= acc_q + 68'(prod);
		if (cmd.div_capture) begin
			unique case (cmd.div_sel)
				DIV_SEL_Y:   qx_q <= wz ? '0 : signed'(quo);
				DIV_SEL_Z:   qy_q <= wz ? '0 : signed'(quo);
				DIV_SEL_ONE: if (!cmd.dot_step) qz_q <= wz ? '0 : signed'(quo);
					else inv_q <= wz ? '0 : signed'(quo);
				default: ;
			endcase
		end
		if (cmd.scr_x) sx_q <= scl;
		if (cmd.scr_y) sy_q <= scl;
		if (cmd.store && vc_q != 2'd2) begin
			hx_q[vc_q[0]] <= sx_q;
			hy_q[vc_q[0]] <= sy_q;
			hd_q[vc_q[0]] <= dpv;
			hi_q[vc_q[0]] <= ivv;
		end
	end

	logic [28:0] lx_q, ly_q;
	logic [16:0] ld_q;
	logic [31:0] li_q;
	always_ff @(posedge clk)
		if (cmd.store && vc_q == 2'd2) begin
			lx_q <= sx_q; ly_q <= sy_q; ld_q <= dpv; li_q <= ivv;
		end

	always_comb begin
		if (oslot_q == 2'd2) begin
			screen_x = lx_q; screen_y = ly_q; depth = ld_q; inverse_w = li_q;
		end else begin
			screen_x  = hx_q[oslot_q[0]];
			screen_y  = hy_q[oslot_q[0]];
			depth     = hd_q[oslot_q[0]];
			inverse_w = hi_q[oslot_q[0]];
		end
	end
	assign vertex_slot      = oslot_q;
	assign last_of_triangle = (oslot_q == 2'd2);

	assign sts.div_done    = div_done;
	assign sts.dot_done    = (dcnt_q == 2'd2);
	assign sts.last_vertex = (vc_q == 2'd2);
	assign sts.emit        = !rej_v && !(cfg_cull && away_v);
	assign sts.out_last    = (oslot_q == 2'd2);

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_slot != 2'd3) else $error("slot out of range");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		vc_q != 2'd3) else $error("vertex count out of range");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store && vc_q == 2'd2 |=> vc_q == 2'd0 && !rej_q && away_q)
		else $error("triangle state not restarted");
endmodule
`default_nettype wire

@@ dv/triangle_clip_cull_viewport_core_test.sv @@
`default_nettype none
module triangle_clip_cull_viewport_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tccv_pkg::*;

	localparam longint ONE = 64'sd65536;
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 600;
	localparam logic signed [31:0] SMAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] SMIN = 32'sh80000000;

	typedef struct {
		logic signed [31:0] cx, cy, cz, cw;
		logic signed [31:0] nx, ny, nz;
		logic signed [31:0] wx, wy, wz;
	} vertex_t;

	typedef struct {
		logic [28:0] sx, sy;
		logic [16:0] dp;
		logic [31:0] iw;
		logic [1:0]  slot;
		logic        last;
	} screen_vertex_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [31:0] clip_x = '0, clip_y = '0, clip_z = '0, clip_w = '0;
	logic [31:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic [31:0] world_x = '0, world_y = '0, world_z = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [28:0] screen_x, screen_y;
	logic [16:0] depth;
	logic [31:0] inverse_w;
	logic [1:0] vertex_slot;
	logic last_of_triangle;

	triangle_clip_cull_viewport_core DUT (.*);

	always #6 clk = ~clk;

	logic [12:0] cfg_width = 13'd640, cfg_height = 13'd480;
	logic cfg_cull = 0;
	logic signed [31:0] cfg_cam_x = 0, cfg_cam_y = 0, cfg_cam_z = 0;

	logic [1:0] tri_count = 0;
	logic tri_rejected = 0;
	logic tri_away = 1;
	screen_vertex_t held_vertex [2];

	screen_vertex_t expected_vertices[$];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_timer = 0;

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	function automatic logic [28:0] to_screen(longint q, logic [12:0] size);
		longint t, s;
		t = q + ONE;
		if (t < 0) t = 0;
		if (t > 2 * ONE) t = 2 * ONE;
		s = (t * longint'(size)) >>> 1;
		if (s > 64'sh1FFFFFFF) s = 64'sh1FFFFFFF;
		return s[28:0];
	endfunction

	function automatic bit faces_camera(vertex_t v);
		logic signed [127:0] acc, n, d;
		acc = 0;
		n = v.nx; d = longint'(v.wx) - longint'(cfg_cam_x); acc += n * d;
		n = v.ny; d = longint'(v.wy) - longint'(cfg_cam_y); acc += n * d;
		n = v.nz; d = longint'(v.wz) - longint'(cfg_cam_z); acc += n * d;
		return acc < 0;
	endfunction

	task automatic predict_vertex(vertex_t v);
		longint qx, qy, qz, inv;
		screen_vertex_t r;
		qx = 0; qy = 0; qz = 0; inv = 0;
		if (v.cw == 0) begin
			tri_rejected = 1;
		end else begin
			qx = (longint'(v.cx) * ONE) / longint'(v.cw);
			qy = (longint'(v.cy) * ONE) / longint'(v.cw);
			qz = (longint'(v.cz) * ONE) / longint'(v.cw);
			inv = (ONE * ONE) / longint'(v.cw);
			if (inv > longint'(SMAX)) inv = longint'(SMAX);
			if (inv < longint'(SMIN)) inv = longint'(SMIN);
			if (qx > ONE || qx < -ONE || qy > ONE || qy < -ONE || qz > ONE || qz < 0)
				tri_rejected = 1;
		end
		if (faces_camera(v))
			tri_away = 0;
		r.sx = to_screen(qx, cfg_width);
		r.sy = to_screen(qy, cfg_height);
		r.dp = (qz < 0) ? 17'd0 : (qz > 64'sh1FFFF) ? 17'h1FFFF : qz[16:0];
		r.iw = inv[31:0];
		if (tri_count < 2) begin
			held_vertex[tri_count] = r;
			tri_count++;
		end else begin
			if (!tri_rejected && !(cfg_cull && tri_away)) begin
				for (int k = 0; k < 2; k++) begin
					held_vertex[k].slot = k;
					held_vertex[k].last = 0;
					expected_vertices.push_back(held_vertex[k]);
				end
				r.slot = 2;
				r.last = 1;
				expected_vertices.push_back(r);
			end
			tri_count = 0;
			tri_rejected = 0;
			tri_away = 1;
		end
	endtask

	task automatic write_register(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_WIDTH:  cfg_width = value[12:0];
			REG_HEIGHT: cfg_height = value[12:0];
			REG_CULL:   cfg_cull = value[0];
			REG_CAM_X:  cfg_cam_x = value;
			REG_CAM_Y:  cfg_cam_y = value;
			REG_CAM_Z:  cfg_cam_z = value;
			default: ;
		endcase
	endtask

	task automatic send_vertex(vertex_t v);
		bit taken;
		if (burst_left == 0) begin
			int gap;
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1;
		clip_x <= v.cx; clip_y <= v.cy; clip_z <= v.cz; clip_w <= v.cw;
		normal_x <= v.nx; normal_y <= v.ny; normal_z <= v.nz;
		world_x <= v.wx; world_y <= v.wy; world_z <= v.wz;
		do begin
			@(negedge clk);
			taken = !in_stall;
			if (taken) predict_vertex(v);
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic settle();
		in_valid <= 0;
		burst_left = 0;
		while (expected_vertices.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic vertex_t mk(logic signed [31:0] x, y, z, w,
			logic signed [31:0] nx = 0, ny = 0, nz = 0,
			logic signed [31:0] px = 0, py = 0, pz = 0);
		vertex_t v;
		v.cx = x; v.cy = y; v.cz = z; v.cw = w;
		v.nx = nx; v.ny = ny; v.nz = nz;
		v.wx = px; v.wy = py; v.wz = pz;
		return v;
	endfunction

	function automatic logic signed [31:0] scale_of_w(logic signed [31:0] w, int r);
		longint p;
		p = (longint'(w) * longint'(r)) / ONE;
		return p[31:0];
	endfunction

	function automatic vertex_t visible_vertex();
		vertex_t v;
		logic signed [31:0] w;
		w = ($urandom_range(0, 1)) ? $urandom_range(1, 32'h7FFFFFFF) : $urandom_range(1, 65535);
		if ($urandom_range(0, 1)) w = -w;
		v.cw = w;
		v.cx = scale_of_w(w, $urandom_range(0, 131072) - 65536);
		v.cy = scale_of_w(w, $urandom_range(0, 131072) - 65536);
		v.cz = scale_of_w(w, $urandom_range(0, 65536));
		v.nx = $urandom; v.ny = $urandom; v.nz = $urandom;
		v.wx = $urandom; v.wy = $urandom; v.wz = $urandom;
		if ($urandom_range(0, 1)) begin
			v.nx = $signed(v.nx) >>> 16; v.ny = $signed(v.ny) >>> 16;
			v.nz = $signed(v.nz) >>> 16;
		end
		return v;
	endfunction

	function automatic vertex_t noise_vertex();
		vertex_t v;
		v.cx = $urandom; v.cy = $urandom; v.cz = $urandom;
		v.cw = ($urandom_range(0, 7) == 0) ? 32'sd0 : $urandom;
		v.nx = $urandom; v.ny = $urandom; v.nz = $urandom;
		v.wx = $urandom; v.wy = $urandom; v.wz = $urandom;
		return v;
	endfunction

	task automatic test_clip_edges();
		send_vertex(mk(0, 0, 0, ONE));
		send_vertex(mk(ONE, ONE, ONE, ONE));
		send_vertex(mk(-ONE, -ONE, 0, ONE));
		send_vertex(mk(0, 0, 0, ONE));
		send_vertex(mk(0, 0, 0, 0));
		send_vertex(mk(0, 0, 0, ONE));
		send_vertex(mk(ONE + 1, 0, 0, ONE));
		send_vertex(mk(0, -ONE - 1, 0, ONE));
		send_vertex(mk(0, 0, -1, ONE));
		send_vertex(mk(0, 0, 0, 1));
		send_vertex(mk(0, 0, 0, -1));
		send_vertex(mk(SMAX, SMAX, SMAX, SMAX));
		send_vertex(mk(SMIN, SMAX, SMIN, SMIN));
		send_vertex(mk(-ONE, ONE, ONE / 2, ONE));
		send_vertex(mk(0, 0, ONE + 1, ONE));
		settle();
	endtask

	task automatic test_viewport_sizes();
		logic [12:0] sizes [5] = '{13'd1, 13'd4096, 13'h1FFF, 13'd0, 13'd333};
		foreach (sizes[i]) begin
			write_register(REG_WIDTH, {19'h7FFFF, sizes[i]});
			write_register(REG_HEIGHT, sizes[(i + 2) % 5]);
			send_vertex(mk(ONE, -ONE, ONE, ONE));
			send_vertex(mk(-ONE, ONE, 0, ONE));
			send_vertex(mk(ONE / 3, -ONE / 7, ONE / 2, ONE));
			settle();
		end
		write_register(REG_SPARE_A, 32'hFFFFFFFF);
		write_register(REG_SPARE_B, 32'h00000001);
	endtask

	task automatic test_back_face_cull();
		write_register(REG_CULL, 32'hFFFFFFFF);
		write_register(REG_CAM_X, 0);
		write_register(REG_CAM_Y, 0);
		write_register(REG_CAM_Z, 0);
		repeat (3) send_vertex(mk(0, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
		send_vertex(mk(0, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
		send_vertex(mk(0, 0, 0, ONE, 0, 0, ONE, 0, 0, -ONE));
		send_vertex(mk(0, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
		settle();
		write_register(REG_CAM_X, SMIN);
		write_register(REG_CAM_Y, SMAX);
		write_register(REG_CAM_Z, SMIN);
		send_vertex(mk(0, 0, 0, ONE, SMIN, 0, 0, SMAX, 0, 0));
		repeat (2) send_vertex(mk(0, 0, 0, ONE, SMAX, SMAX, 0, SMAX, SMIN, SMIN));
		repeat (3) send_vertex(mk(0, 0, 0, ONE, SMAX, SMIN, SMAX, SMAX, SMIN, SMAX));
		settle();
	endtask

	task automatic test_random_triangles();
		for (int phase = 0; phase < 4; phase++) begin
			write_register(REG_WIDTH, $urandom_range(1, 4096));
			write_register(REG_HEIGHT, $urandom_range(1, 4096));
			write_register(REG_CULL, phase[0]);
			write_register(REG_CAM_X, $urandom);
			write_register(REG_CAM_Y, (phase == 3) ? 32'h0 : $urandom);
			write_register(REG_CAM_Z, $urandom);
			for (int t = 0; t < 10; t++) begin
				int bad;
				bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : -1;
				for (int k = 0; k < 3; k++)
					send_vertex((k == bad) ? noise_vertex() : visible_vertex());
			end
			if ($urandom_range(0, 1)) send_vertex(noise_vertex());
			settle();
			while (tri_count != 0) send_vertex(visible_vertex());
			settle();
		end
	endtask

	always @(posedge clk) begin
		if (stall_timer == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_timer <= $urandom_range(100, 1500);
		end else begin
			stall_timer <= stall_timer - 1;
		end
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= $urandom_range(0, 1);
			default: out_stall <= (stall_timer % 64) < 40;
		endcase
	end

	always @(negedge clk) begin
		screen_vertex_t want;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_vertices.size() == 0) begin
				report_mismatch("unexpected result slot", vertex_slot, 0);
			end else begin
				want = expected_vertices.pop_front();
				if (screen_x !== want.sx) report_mismatch("screen_x", screen_x, want.sx);
				if (screen_y !== want.sy) report_mismatch("screen_y", screen_y, want.sy);
				if (depth !== want.dp) report_mismatch("depth", depth, want.dp);
				if (inverse_w !== want.iw) report_mismatch("inverse_w", inverse_w, want.iw);
				if (vertex_slot !== want.slot)
					report_mismatch("vertex_slot", vertex_slot, want.slot);
				if (last_of_triangle !== want.last)
					report_mismatch("last_of_triangle", last_of_triangle, want.last);
			end
		end
		if (idle_cycles > IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);
		test_clip_edges();
		test_viewport_sizes();
		test_back_face_cull();
		test_random_triangles();
		settle();
		if (errors == 0 && expected_vertices.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
